// ----- rtl/pps_pkg.sv -----
// Package for the point-to-plane projection unit.
// Holds the payload structs and the datapath width constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  // Multiplier operand limbs and widths.
  localparam int MUL_LIMB = 34;
  localparam int MUL_A_W  = 3 * MUL_LIMB;
  localparam int MUL_B_W  = 2 * MUL_LIMB;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // Divider widths: numerator magnitude, divisor magnitude, quotient bits.
  localparam int NUM_W    = MUL_P_W;
  localparam int DEN_W    = 134;
  localparam int DIV_Q_W  = 36;

  // One input transfer: the point and three plane points.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } pps_in_t;

  // One result transfer: projected point and squared distance.
  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic        [31:0] dist_sq;
  } pps_out_t;

endpackage

`default_nettype wire

// ----- rtl/pps_mul.sv -----
// Three-stage pipelined unsigned multiplier, 102 x 68 bits.
// Uses MUL_* widths from pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_mul import pps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] p
);

  logic [2*MUL_LIMB-1:0] pp_r  [3][2];
  logic [4*MUL_LIMB-1:0] row_r [2];
  logic [MUL_P_W-1:0]    p_r;

  // Stage one: the six limb partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp_r[i][j] <= a[MUL_LIMB*i +: MUL_LIMB] * b[MUL_LIMB*j +: MUL_LIMB];
        end
      end
    end
  end

  // Stage two: one row per limb of b. The outer partial products do not
  // overlap, so they are concatenated and only the middle one is added.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        row_r[j] <= {pp_r[2][j], pp_r[0][j]} +
                    {{MUL_LIMB{1'b0}}, pp_r[1][j], {MUL_LIMB{1'b0}}};
      end
    end
  end

  // Stage three: merge the two rows.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= {{MUL_LIMB{1'b0}}, row_r[0]} + {row_r[1], {MUL_LIMB{1'b0}}};
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- rtl/pps_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Carries the quotient sign and one coordinate alongside; uses pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_div import pps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  input  wire logic               sgn,
  input  wire logic [31:0]        side,
  output logic      [DIV_Q_W-1:0] q,
  output logic                    sgn_o,
  output logic      [31:0]        side_o
);

  logic [NUM_W-1:0]   rem_r  [DIV_Q_W-1];
  logic [DEN_W-1:0]   den_r  [DIV_Q_W-1];
  logic [DIV_Q_W-1:0] q_r    [DIV_Q_W];
  logic               sgn_r  [DIV_Q_W];
  logic [31:0]        side_r [DIV_Q_W];

  // The quotient is known to fit in DIV_Q_W bits, so the first stage
  // tries the divisor shifted by DIV_Q_W-1 and each stage halves it.
  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    localparam int SH = DIV_Q_W - 1 - k;
    logic [NUM_W-1:0]   rem_in;
    logic [DEN_W-1:0]   den_in;
    logic [DIV_Q_W-1:0] q_in;
    logic               sgn_in;
    logic [31:0]        side_in;
    logic [NUM_W-1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign sgn_in  = sgn;
      assign side_in = side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign sgn_in  = sgn_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = NUM_W'(den_in) << SH;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= {q_in[DIV_Q_W-2:0], ge};
        sgn_r[k]  <= sgn_in;
        side_r[k] <= side_in;
      end
    end

    // The last stage needs no remainder or divisor afterwards.
    if (k < DIV_Q_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rem_in - trial) : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign q      = q_r[DIV_Q_W-1];
  assign sgn_o  = sgn_r[DIV_Q_W-1];
  assign side_o = side_r[DIV_Q_W-1];

endmodule

`default_nettype wire

// ----- rtl/pps_outq.sv -----
// Two-entry result queue that decouples the pipeline from the consumer.
// Uses pps_out_t from pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_outq import pps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire pps_out_t din,
  output logic          space,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pps_out_t      out_data
);

  pps_out_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  // The pipeline may move whenever a slot is free or one leaves now.
  assign space     = (cnt_r != 2'd2) || out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && (cnt_r == 2'd2) |-> out_ready)
    else $error("result pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r)))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/point_to_plane_projection_unit.sv -----
// Top level of the point-to-plane projection unit.
// Depends on pps_pkg, pps_mul, pps_div and pps_outq.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid / in_ready     | in_data  (pps_in_t)
//   out     | output    | out_valid / out_ready   | out_data (pps_out_t)
//
// One transfer in per cycle, one result out per cycle, sustained while out_ready stays high.
// The two 3-stage wide multipliers and the 36-stage divider set the
// pipeline depth; finished results then pass through the result queue.
// Reset (rst_n low, synchronous) clears the stage valid bits and the queue.
// A stall stops every stage together; the two-entry queue lets the input
// keep accepting while one finished result waits.
`timescale 1ns / 1ps
`default_nettype none

module point_to_plane_projection_unit import pps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pps_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pps_out_t      out_data
);

  localparam int NSTG = 50;

  logic            en;
  logic [NSTG-1:0] vld_r;
  logic            push;

  logic signed [31:0] in_p [3];
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_b [3];
  logic signed [31:0] in_c [3];

  logic signed [31:0] p_dly_r [12][3];
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [32:0] d1_r [3];
  logic signed [65:0] pr_r [6];
  logic signed [32:0] d2_r [3];
  logic signed [66:0] n_r  [3];
  logic signed [32:0] d3_r [3];
  logic [65:0]        nmag_r [3];
  logic               nsgn_r [3];
  logic [32:0]        dmag_r [3];
  logic               dsgn_r [3];

  logic [65:0]        nm_dly_r [5][3];
  logic               ns_dly_r [5][3];
  logic               ds_dly_r [3][3];

  logic [MUL_P_W-1:0] nd_p [3];
  logic [MUL_P_W-1:0] nn_p [3];
  logic [MUL_P_W-1:0] num_p [3];

  logic signed [100:0] dot_r;
  logic [DEN_W-1:0]    nsq_r;
  logic [99:0]         dotmag_r;
  logic                dotsgn_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    den_dly_r [3];
  logic                sg_dly_r  [3][3];

  logic [DIV_Q_W-1:0]  q_w    [3];
  logic                qs_w   [3];
  logic [31:0]         qp_w   [3];

  logic signed [36:0]  off_r  [3];
  logic [47:0]         sq_r   [3];
  logic                big_r;
  logic signed [31:0]  p49_r  [3];
  pps_out_t            res_r;

  // Global stage enable: every stage moves while the queue has room.
  assign in_ready = en;
  assign push     = en && vld_r[NSTG-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_comb begin
    in_p[0] = in_data.px; in_p[1] = in_data.py;       in_p[2] = in_data.pz;
    in_a[0] = in_data.ax; in_a[1] = in_data.ay;       in_a[2] = in_data.az;
    in_b[0] = in_data.bx; in_b[1] = in_data.by_coord; in_b[2] = in_data.bz;
    in_c[0] = in_data.cx; in_c[1] = in_data.cy;       in_c[2] = in_data.cz;
  end

  // Point delay line up to the divider entry.
  always_ff @(posedge clk) begin
    if (en) begin
      p_dly_r[0] <= in_p;
      for (int i = 1; i < 12; i++) begin
        p_dly_r[i] <= p_dly_r[i-1];
      end
    end
  end

  // Stage 1: edge vectors and the offset from the point to the plane.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= 33'(in_b[k]) - 33'(in_a[k]);
        e2_r[k] <= 33'(in_c[k]) - 33'(in_a[k]);
        d1_r[k] <= 33'(in_a[k]) - 33'(in_p[k]);
      end
    end
  end

  // Stage 2: cross product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= e1_r[1] * e2_r[2];
      pr_r[1] <= e1_r[2] * e2_r[1];
      pr_r[2] <= e1_r[2] * e2_r[0];
      pr_r[3] <= e1_r[0] * e2_r[2];
      pr_r[4] <= e1_r[0] * e2_r[1];
      pr_r[5] <= e1_r[1] * e2_r[0];
      d2_r    <= d1_r;
    end
  end

  // Stage 3: plane normal.
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= 67'(pr_r[0]) - 67'(pr_r[1]);
      n_r[1] <= 67'(pr_r[2]) - 67'(pr_r[3]);
      n_r[2] <= 67'(pr_r[4]) - 67'(pr_r[5]);
      d3_r   <= d2_r;
    end
  end

  // Stage 4: split normal and offset into sign and magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nmag_r[k] <= n_r[k][66] ? 66'(-n_r[k]) : 66'(n_r[k]);
        nsgn_r[k] <= n_r[k][66];
        dmag_r[k] <= d3_r[k][32] ? 33'(-d3_r[k]) : 33'(d3_r[k]);
        dsgn_r[k] <= d3_r[k][32];
      end
    end
  end

  // Sign and normal magnitude delay lines for the multiplier stages.
  always_ff @(posedge clk) begin
    if (en) begin
      nm_dly_r[0] <= nmag_r;
      ns_dly_r[0] <= nsgn_r;
      ds_dly_r[0] <= dsgn_r;
      for (int i = 1; i < 5; i++) begin
        nm_dly_r[i] <= nm_dly_r[i-1];
        ns_dly_r[i] <= ns_dly_r[i-1];
      end
      for (int i = 1; i < 3; i++) begin
        ds_dly_r[i] <= ds_dly_r[i-1];
      end
    end
  end

  // Stages 5 to 7: N.D terms and |N|^2 terms.
  for (genvar k = 0; k < 3; k++) begin : g_mul1
    pps_mul u_nd (
      .clk (clk),
      .en  (en),
      .a   ({36'd0, nmag_r[k]}),
      .b   ({35'd0, dmag_r[k]}),
      .p   (nd_p[k])
    );
    pps_mul u_nn (
      .clk (clk),
      .en  (en),
      .a   ({36'd0, nmag_r[k]}),
      .b   ({2'd0, nmag_r[k]}),
      .p   (nn_p[k])
    );
  end

  // Stage 8: dot product and squared normal length.
  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= ((ns_dly_r[2][0] ^ ds_dly_r[2][0]) ? -$signed({2'b0, nd_p[0][98:0]})
                                                  :  $signed({2'b0, nd_p[0][98:0]}))
             + ((ns_dly_r[2][1] ^ ds_dly_r[2][1]) ? -$signed({2'b0, nd_p[1][98:0]})
                                                  :  $signed({2'b0, nd_p[1][98:0]}))
             + ((ns_dly_r[2][2] ^ ds_dly_r[2][2]) ? -$signed({2'b0, nd_p[2][98:0]})
                                                  :  $signed({2'b0, nd_p[2][98:0]}));
      nsq_r <= {2'd0, nn_p[0][131:0]} + {2'd0, nn_p[1][131:0]} + {2'd0, nn_p[2][131:0]};
    end
  end

  // Stage 9: dot magnitude; a zero normal divides by one LSB.
  always_ff @(posedge clk) begin
    if (en) begin
      dotmag_r <= dot_r[100] ? 100'(-dot_r) : 100'(dot_r);
      dotsgn_r <= dot_r[100];
      den_r    <= (nsq_r == '0) ? DEN_W'(1) : nsq_r;
    end
  end

  // Stages 10 to 12: numerators N_k * (N.D).
  for (genvar k = 0; k < 3; k++) begin : g_mul2
    pps_mul u_num (
      .clk (clk),
      .en  (en),
      .a   ({2'd0, dotmag_r}),
      .b   ({2'd0, nm_dly_r[4][k]}),
      .p   (num_p[k])
    );
  end

  // Divisor and quotient sign alongside the second multiplier.
  always_ff @(posedge clk) begin
    if (en) begin
      den_dly_r[0] <= den_r;
      for (int k = 0; k < 3; k++) begin
        sg_dly_r[0][k] <= ns_dly_r[4][k] ^ dotsgn_r;
      end
      for (int i = 1; i < 3; i++) begin
        den_dly_r[i] <= den_dly_r[i-1];
        sg_dly_r[i]  <= sg_dly_r[i-1];
      end
    end
  end

  // Stages 13 to 48: one divider per axis.
  for (genvar k = 0; k < 3; k++) begin : g_div
    pps_div u_div (
      .clk    (clk),
      .en     (en),
      .num    (num_p[k]),
      .den    (den_dly_r[2]),
      .sgn    (sg_dly_r[2][k]),
      .side   (p_dly_r[11][k]),
      .q      (q_w[k]),
      .sgn_o  (qs_w[k]),
      .side_o (qp_w[k])
    );
  end

  // Stage 49: signed offsets and squared terms.
  always_ff @(posedge clk) begin
    if (en) begin
      big_r <= (q_w[0][35:24] != '0) || (q_w[1][35:24] != '0) ||
               (q_w[2][35:24] != '0);
      for (int k = 0; k < 3; k++) begin
        off_r[k] <= qs_w[k] ? -$signed({1'b0, q_w[k]}) : $signed({1'b0, q_w[k]});
        sq_r[k]  <= q_w[k][23:0] * q_w[k][23:0];
        p49_r[k] <= qp_w[k];
      end
    end
  end

  // Stage 50: projected point with saturation and the squared distance.
  logic signed [37:0] sum_w [3];
  logic signed [31:0] prj_w [3];
  logic [49:0]        dsum_w;
  logic [31:0]        dist_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_w[k] = 38'(p49_r[k]) + 38'(off_r[k]);
      if (sum_w[k][37:31] == 7'h00 || sum_w[k][37:31] == 7'h7f) begin
        prj_w[k] = sum_w[k][31:0];
      end else if (sum_w[k][37]) begin
        prj_w[k] = 32'sh8000_0000;
      end else begin
        prj_w[k] = 32'sh7fff_ffff;
      end
    end
    dsum_w = {2'd0, sq_r[0]} + {2'd0, sq_r[1]} + {2'd0, sq_r[2]};
    dist_w = (big_r || (dsum_w[49:48] != 2'd0)) ? 32'hffff_ffff : dsum_w[47:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.proj_x  <= prj_w[0];
      res_r.proj_y  <= prj_w[1];
      res_r.proj_z  <= prj_w[2];
      res_r.dist_sq <= dist_w;
    end
  end

  pps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (res_r),
    .space     (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transfer did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    en && !vld_r[NSTG-2] |=> !vld_r[NSTG-1])
    else $error("result appeared without a predecessor");

endmodule

`default_nettype wire

// ----- sim/tb_point_to_plane_projection_unit.sv -----
// Testbench for the point-to-plane projection unit: random and directed queries,
// with results checked against an exact wide-integer projection predictor.
// Depends on pps_pkg and point_to_plane_projection_unit.
`timescale 1ns / 1ps

module tb_point_to_plane_projection_unit;
  import pps_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 3000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pps_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pps_out_t out_data;

  pps_in_t  query_q[$];
  pps_out_t proj_expect_q[$];
  int       mismatch_cnt;
  int       idle_cnt;
  int       cycle_cnt;
  bit       in_fire;
  bit       calm;

  point_to_plane_projection_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Exact projection: normal from the cross product, offset = N * (N.D) / |N|^2.
  function automatic pps_out_t project_point(pps_in_t q);
    wide_t      p[3], a[3], b[3], c[3], e1[3], e2[3], d[3], nv[3];
    wide_t      dotp, nsq, quo;
    logic signed [63:0] off[3], s;
    logic [63:0] mag, sum;
    logic [31:0] res[3];
    bit          big;
    pps_out_t    r;
    p[0] = $signed(q.px); p[1] = $signed(q.py);       p[2] = $signed(q.pz);
    a[0] = $signed(q.ax); a[1] = $signed(q.ay);       a[2] = $signed(q.az);
    b[0] = $signed(q.bx); b[1] = $signed(q.by_coord); b[2] = $signed(q.bz);
    c[0] = $signed(q.cx); c[1] = $signed(q.cy);       c[2] = $signed(q.cz);
    for (int k = 0; k < 3; k++) begin
      e1[k] = b[k] - a[k];
      e2[k] = c[k] - a[k];
      d[k]  = a[k] - p[k];
    end
    nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
    dotp = nv[0] * d[0] + nv[1] * d[1] + nv[2] * d[2];
    nsq  = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
    sum = '0;
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      // A degenerate plane divides by one LSB of a zero numerator.
      if (nsq == 0) begin
        off[k] = '0;
      end else begin
        quo = (nv[k] * dotp) / nsq;
        mag = (quo < 0) ? 64'(-quo) : 64'(quo);
        mag &= 64'h0000_000F_FFFF_FFFF;
        off[k] = (quo < 0) ? -$signed(mag) : $signed(mag);
      end
      s = 64'($signed(p[k])) + off[k];
      if (s > 64'sd2147483647) res[k] = 32'h7FFF_FFFF;
      else if (s < -64'sd2147483648) res[k] = 32'h8000_0000;
      else res[k] = s[31:0];
      if (off[k] >= (64'sd1 <<< 24) || off[k] <= -(64'sd1 <<< 24)) big = 1'b1;
      else sum += 64'(off[k] * off[k]);
    end
    sum = sum >> 16;
    r.proj_x  = res[0];
    r.proj_y  = res[1];
    r.proj_z  = res[2];
    r.dist_sq = (big || sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Random query; mostly moderate coordinates so the arithmetic stays in range.
  function automatic pps_in_t random_query();
    pps_in_t     q;
    int unsigned kind;
    int          f;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      q.px = rand_coord(kind < 30 ? 32'h7FFF_0000 : 32'h0040_0000);
      q.py = rand_coord(kind < 30 ? 32'h7FFF_0000 : 32'h0040_0000);
      q.pz = rand_coord(kind < 30 ? 32'h7FFF_0000 : 32'h0040_0000);
      q.ax = rand_coord(32'h0010_0000);
      q.ay = rand_coord(32'h0010_0000);
      q.az = rand_coord(32'h0010_0000);
      q.bx = rand_coord(32'h0010_0000);
      q.by_coord = rand_coord(32'h0010_0000);
      q.bz = rand_coord(32'h0010_0000);
      if (kind < 40) begin
        // Collinear third point gives a degenerate plane.
        f = $urandom_range(0, 6) - 3;
        q.cx = q.ax + f * (q.bx - q.ax);
        q.cy = q.ay + f * (q.by_coord - q.ay);
        q.cz = q.az + f * (q.bz - q.az);
      end else begin
        q.cx = rand_coord(32'h0010_0000);
        q.cy = rand_coord(32'h0010_0000);
        q.cz = rand_coord(32'h0010_0000);
      end
    end
    return q;
  endfunction

  // Append a query to the pending list.
  task automatic add_query(pps_in_t item);
    query_q = {query_q, item};
  endtask

  // Append an expected result to the scoreboard.
  task automatic add_expect(pps_out_t item);
    proj_expect_q = {proj_expect_q, item};
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  // Driver: inputs change at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (query_q.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          in_valid <= 1'b1;
          in_data  <= query_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  // Monitor: transfers are sampled at the rising edge.
  always @(posedge clk) begin
    pps_out_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      cycle_cnt++;
      idle_cnt++;
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        idle_cnt = 0;
        add_expect(project_point(in_data));
      end
      if (out_valid && out_ready) begin
        idle_cnt = 0;
        if (proj_expect_q.size() == 0) begin
          report_mismatch("unexpected result transfer", out_data.dist_sq, 32'h0);
        end else begin
          want = proj_expect_q.pop_front();
          if (out_data.proj_x !== want.proj_x)
            report_mismatch("proj_x", out_data.proj_x, want.proj_x);
          if (out_data.proj_y !== want.proj_y)
            report_mismatch("proj_y", out_data.proj_y, want.proj_y);
          if (out_data.proj_z !== want.proj_z)
            report_mismatch("proj_z", out_data.proj_z, want.proj_z);
          if (out_data.dist_sq !== want.dist_sq)
            report_mismatch("dist_sq", out_data.dist_sq, want.dist_sq);
        end
      end
      if (idle_cnt >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    pps_in_t q;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    mismatch_cnt = 0;
    idle_cnt     = 0;
    cycle_cnt    = 0;
    calm         = 1'b0;

    // Directed: zero, extremes, degenerate planes, saturation, huge distance.
    add_query('0);
    add_query({12{32'h7FFF_FFFF}});
    add_query({12{32'h8000_0000}});
    add_query({12{32'hFFFF_FFFF}});
    // Unit plane z = 0, point above it.
    add_query({32'h0001_0000, 32'h0002_0000, 32'h0005_0000,
               32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
               32'h0, 32'h0001_0000, 32'h0});
    // Collinear and coincident plane points.
    add_query({32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
               32'h0003_0000, 32'h0003_0000, 32'h0003_0000});
    add_query({32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF,
               {9{32'h0000_0042}}});
    // Plane points at the extremes of the range; distance saturates.
    add_query({32'h7FFF_0000, 32'h0, 32'h0,
               32'h8000_0000, 32'h0, 32'h0,
               32'h8000_0000, 32'h0001_0000, 32'h0,
               32'h8000_0000, 32'h0, 32'h0001_0000});
    add_query({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h0, 32'h0,
               32'h0, 32'h7FFF_FFFF, 32'h0,
               32'h0, 32'h0, 32'h7FFF_FFFF});
    // Tiny tilted plane whose offset is under three LSBs on each axis.
    add_query({32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003,
               32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
               32'h0000_0004, 32'h0000_0001, 32'hFFFF_FFFE,
               32'hFFFF_FFFD, 32'h0000_0005, 32'h0000_0001});
    for (int i = 0; i < 10; i++) begin
      q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      add_query(q);
    end
    for (int i = 0; i < 1200; i++) add_query(random_query());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A quiet window with no idling on either side.
    wait (query_q.size() < 800);
    calm = 1'b1;
    wait (query_q.size() < 550);
    calm = 1'b0;

    wait (query_q.size() == 0 && !in_valid);
    wait (proj_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && proj_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
